// ===== hw/rtl/prba_pkg.sv =====
// Package for the pixel region bin averager: payload structs, sizes, codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package prba_pkg;
	localparam int RINGS       = 32;
	localparam int INNER_SKIP  = 10;
	localparam int MAX_SECTORS = 512;
	localparam int CELLS       = MAX_SECTORS * RINGS;
	localparam int AW          = $clog2(CELLS);
	localparam int SUM_W       = 33;
	localparam int CNT_W       = 25;
	localparam int SEC_W       = $clog2(MAX_SECTORS);
	localparam int RING_W      = $clog2(RINGS);
	localparam int BANDS       = (RINGS > INNER_SKIP) ? (RINGS - INNER_SKIP) : 1;
	// reciprocal of BANDS, exact for every 13-bit height when BANDS is at most 64
	localparam int BAND_SHIFT  = 20;
	localparam int BAND_RECIP  = ((1 << BAND_SHIFT) + BANDS - 1) / BANDS;

	localparam logic [1:0] REG_SECTORS = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_WIDTH   = 2'd2;

	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [8:0]  sector_index;
		logic [4:0]  ring_index;
	} prba_in_t;

	typedef struct packed {
		logic [7:0] avg_blue;
		logic [7:0] avg_green;
		logic [7:0] avg_red;
	} prba_out_t;

	// one cell entry: three sums and the count
	typedef struct packed {
		logic [SUM_W-1:0] sb;
		logic [SUM_W-1:0] sg;
		logic [SUM_W-1:0] sr;
		logic [CNT_W-1:0] cnt;
	} prba_cell_t;
endpackage

// ===== hw/rtl/pixel_region_bin_averager.sv =====
// Top level of the pixel region bin averager: sequencer, cell memory, divider.
// Depends on prba_pkg and prba_div.
//
// After reset the block sweeps the 16384-entry cell memory, one entry a cycle,
// setting every sum and count to one; busy stays high for the whole sweep.
// Each division on the single serial divider is a load, one quotient step per
// bit of the 33-bit dividend and a done strobe. An accumulate keeps busy high
// through three divisions (strip size, column by strip, height offset by band),
// the band size, which comes from a reciprocal multiply, and the
// read-modify-write of the cell. A read keeps busy high through the
// registered memory read, three divisions of a colour sum by the
// count, and the cycle in which the averages appear with done high; they
// cannot be held off.
`timescale 1ns / 1ps
module pixel_region_bin_averager import prba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  prba_in_t    in_item,
	output logic        done,
	output prba_out_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_STRIP, ST_BAND, ST_SEC, ST_RING, ST_RD,
		ST_RD_WAIT, ST_WR, ST_DIV_B, ST_DIV_G, ST_DIV_R, ST_OUT
	} state_t;

	state_t           state_q;
	logic [9:0]       sectors_q;
	logic [12:0]      height_q;
	logic [12:0]      width_q;
	logic [AW-1:0]    clr_q;
	prba_in_t         item_q;
	logic [12:0]      strip_q;
	logic [12:0]      band_q;
	logic [SEC_W-1:0] sector_q;
	logic [AW-1:0]    addr_q;
	prba_cell_t       cell_q;
	logic             zero_q;
	logic [7:0]       avg_b_q;
	logic [7:0]       avg_g_q;
	logic             div_wait_q;

	prba_cell_t       mem [CELLS];
	prba_cell_t       rd_s1;
	logic             we;
	logic [AW-1:0]    waddr;
	prba_cell_t       wdata;

	logic             div_go;
	logic [SUM_W-1:0] div_dnd;
	logic [CNT_W-1:0] div_dvs;
	logic             div_done;
	logic [SUM_W-1:0] div_quo;

	logic [10:0]      work_sec;
	logic [12:0]      up;
	logic [CNT_W-1:0] cnt_eff;
	logic [12:0]      quo13;
	logic [33:0]      band_prod;
	logic [12:0]      band_quo;
	logic [RING_W-1:0] ring_nx;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);

	// working sector count limited to 1..MAX_SECTORS
	always_comb begin
		work_sec = {1'b0, sectors_q};
		if (sectors_q == '0)
			work_sec = 11'd1;
		else if ({1'b0, sectors_q} > 11'(MAX_SECTORS))
			work_sec = 11'(MAX_SECTORS);
	end

	assign up      = ({1'b0, item_q.row} < height_q) ? height_q - {1'b0, item_q.row} : '0;
	assign cnt_eff = (cell_q.cnt == '0) ? CNT_W'(1) : cell_q.cnt;
	assign quo13   = (div_quo[SUM_W-1:13] != '0) ? 13'h1fff : div_quo[12:0];

	// band size: height over the band count by reciprocal multiply
	assign band_prod = 34'(height_q) * 34'(BAND_RECIP);
	assign band_quo  = band_prod[BAND_SHIFT +: 13];

	// ring from the height offset quotient, clamped to the outer ring
	assign ring_nx = (quo13 >= 13'(RINGS - INNER_SKIP)) ? RING_W'(RINGS - 1) :
		RING_W'(quo13 + 13'(INNER_SKIP));

	// divider operand selection per phase
	always_comb begin
		div_dnd = '0;
		div_dvs = CNT_W'(1);
		case (state_q)
			ST_STRIP: begin
				div_dnd = SUM_W'(width_q);
				div_dvs = CNT_W'(work_sec);
			end
			ST_SEC: begin
				div_dnd = SUM_W'(item_q.col);
				div_dvs = CNT_W'(strip_q);
			end
			ST_RING: begin
				div_dnd = SUM_W'(up);
				div_dvs = CNT_W'(band_q);
			end
			ST_DIV_B: begin
				div_dnd = cell_q.sb;
				div_dvs = cnt_eff;
			end
			ST_DIV_G: begin
				div_dnd = cell_q.sg;
				div_dvs = cnt_eff;
			end
			ST_DIV_R: begin
				div_dnd = cell_q.sr;
				div_dvs = cnt_eff;
			end
			default: ;
		endcase
	end

	assign div_go = !div_wait_q && (state_q == ST_STRIP ||
		state_q == ST_SEC || state_q == ST_RING || state_q == ST_DIV_B ||
		state_q == ST_DIV_G || state_q == ST_DIV_R);

	prba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dnd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// memory write port: clearing sweep or updated cell
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = cell_q;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '{sb: SUM_W'(1), sg: SUM_W'(1), sr: SUM_W'(1), cnt: CNT_W'(1)};
		end else if (state_q == ST_WR && cell_q.cnt != '1) begin
			we         = 1'b1;
			wdata.sb   = cell_q.sb + SUM_W'(item_q.blue);
			wdata.sg   = cell_q.sg + SUM_W'(item_q.green);
			wdata.sr   = cell_q.sr + SUM_W'(item_q.red);
			wdata.cnt  = cell_q.cnt + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_s1 <= mem[addr_q];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sectors_q <= 10'd360;
			height_q  <= 13'd480;
			width_q   <= 13'd640;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SECTORS: sectors_q <= cfg_data[9:0];
				REG_HEIGHT:  height_q  <= cfg_data;
				REG_WIDTH:   width_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			done       <= 1'b0;
			div_wait_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (div_go)
				div_wait_q <= 1'b1;
			if (div_done)
				div_wait_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						item_q <= in_item;
						addr_q <= {in_item.sector_index[SEC_W-1:0],
							in_item.ring_index[RING_W-1:0]};
						zero_q <= 1'b0;
						state_q <= (in_item.action == ACT_READ) ? ST_RD : ST_STRIP;
					end
				end
				ST_STRIP: if (div_done) begin
					strip_q <= (quo13 == '0) ? 13'd1 : quo13;
					state_q <= ST_BAND;
				end
				ST_BAND: begin
					band_q  <= (band_quo == '0) ? 13'd1 : band_quo;
					state_q <= ST_SEC;
				end
				ST_SEC: if (div_done) begin
					if (quo13 >= 13'(work_sec))
						sector_q <= SEC_W'(work_sec - 11'd1);
					else
						sector_q <= quo13[SEC_W-1:0];
					state_q <= ST_RING;
				end
				ST_RING: if (div_done) begin
					addr_q  <= {sector_q, ring_nx};
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					// rd_s1 holds the cell read in ST_RD; cell_q captures it as this state ends
					state_q <= (item_q.action == ACT_READ) ? ST_DIV_B : ST_WR;
				end
				ST_WR: state_q <= ST_IDLE;
				ST_DIV_B: if (div_done) begin
					avg_b_q <= div_quo[7:0];
					state_q <= ST_DIV_G;
				end
				ST_DIV_G: if (div_done) begin
					avg_g_q <= div_quo[7:0];
					state_q <= ST_DIV_R;
				end
				ST_DIV_R: if (div_done) begin
					out_item <= zero_q ? '0 : '{avg_blue: avg_b_q, avg_green: avg_g_q,
						avg_red: div_quo[7:0]};
					done    <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			// hold the cell read out of memory
			if (state_q == ST_RD_WAIT)
				cell_q <= rd_s1;
		end
	end
endmodule

// ===== hw/rtl/prba_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 33-bit dividend.
// Depends on prba_pkg for widths.
`timescale 1ns / 1ps
module prba_div import prba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);
	localparam int CW = $clog2(SUM_W + 1);
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CW-1:0]    left_q;
	logic             busy_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign quotient = quo_q;

	// shift one bit in per cycle, restore when the trial goes negative
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			left_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				left_q <= CW'(SUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!diff[CNT_W]) begin
					rem_q <= diff[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
				left_q <= left_q - 1'b1;
				if (left_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
